@@ sv/fsc_pkg.sv @@
// types, file type codes and signature match function for the file signature classifier
package fsc_pkg;

  typedef struct packed {
    logic [63:0] head_high;
    logic [63:0] head_low;
  } fsc_in_t;

  typedef struct packed {
    logic [4:0] file_type;
    logic       recognized;
  } fsc_res_t;

  localparam logic [4:0] FT_NONE = 5'd0;
  localparam logic [4:0] FT_JPG  = 5'd1;
  localparam logic [4:0] FT_PNG  = 5'd2;
  localparam logic [4:0] FT_GIF  = 5'd3;
  localparam logic [4:0] FT_TIFF = 5'd4;
  localparam logic [4:0] FT_PSD  = 5'd5;
  localparam logic [4:0] FT_MOV  = 5'd6;
  localparam logic [4:0] FT_M4V  = 5'd7;
  localparam logic [4:0] FT_M4A  = 5'd8;
  localparam logic [4:0] FT_3GP  = 5'd9;
  localparam logic [4:0] FT_MP4  = 5'd10;
  localparam logic [4:0] FT_MKV  = 5'd11;
  localparam logic [4:0] FT_WMV  = 5'd12;
  localparam logic [4:0] FT_SWF  = 5'd13;
  localparam logic [4:0] FT_AVI  = 5'd14;
  localparam logic [4:0] FT_WAV  = 5'd15;
  localparam logic [4:0] FT_MP3  = 5'd16;
  localparam logic [4:0] FT_FLAC = 5'd17;
  localparam logic [4:0] FT_OGG  = 5'd18;
  localparam logic [4:0] FT_PDF  = 5'd19;
  localparam logic [4:0] FT_DOC  = 5'd20;
  localparam logic [4:0] FT_ZIP  = 5'd21;
  localparam logic [4:0] FT_RAR  = 5'd22;
  localparam logic [4:0] FT_7Z   = 5'd23;
  localparam logic [4:0] FT_LAST = FT_7Z;

  function automatic logic [4:0] classify(input fsc_in_t w);
    logic [7:0] b [16];
    logic [4:0] t;
    logic       riff;
    for (int i = 0; i < 8; i++) begin
      b[i]     = w.head_low[8*i +: 8];
      b[i + 8] = w.head_high[8*i +: 8];
    end
    riff = ({b[0], b[1], b[2], b[3]} == "RIFF");
    priority if (b[0] == 8'hFF && b[1] == 8'hD8 && b[2] == 8'hFF &&
                 (b[3] == 8'hE0 || b[3] == 8'hE1 || b[3] == 8'hDB ||
                  b[3] == 8'hE8 || b[3] == 8'hEE)) begin
      t = FT_JPG;
    end else if ({b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} ==
                 64'h89504E47_0D0A1A0A) begin
      t = FT_PNG;
    end else if ({b[0], b[1], b[2], b[3], b[5]} == 40'h47494638_61 &&
                 (b[4] == 8'h37 || b[4] == 8'h39)) begin
      t = FT_GIF;
    end else if ({b[0], b[1], b[2], b[3]} == 32'h49492A00 ||
                 {b[0], b[1], b[2], b[3]} == 32'h4D4D002A) begin
      t = FT_TIFF;
    end else if ({b[0], b[1], b[2], b[3]} == 32'h38425053) begin
      t = FT_PSD;
    end else if ({b[4], b[5], b[6], b[7]} == "ftyp") begin
      priority if ({b[8], b[9]} == "qt") begin
        t = FT_MOV;
      end else if ({b[8], b[9], b[10]} == "M4V" || {b[8], b[9], b[10]} == "m4v") begin
        t = FT_M4V;
      end else if ({b[8], b[9], b[10]} == "M4A") begin
        t = FT_M4A;
      end else if ({b[8], b[9]} == "3g") begin
        t = FT_3GP;
      end else begin
        t = FT_MP4;
      end
    end else if ({b[4], b[5], b[6], b[7]} == "moov" ||
                 {b[4], b[5], b[6], b[7]} == "mdat") begin
      t = FT_MOV;
    end else if ({b[0], b[1], b[2], b[3]} == 32'h1A45DFA3) begin
      t = FT_MKV;
    end else if ({b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} ==
                 64'h3026B275_8E66CF11) begin
      t = FT_WMV;
    end else if ({b[1], b[2]} == "WS" &&
                 (b[0] == "F" || b[0] == "C" || b[0] == "Z")) begin
      t = FT_SWF;
    end else if (riff && {b[8], b[9], b[10], b[11]} == "AVI ") begin
      t = FT_AVI;
    end else if (riff && {b[8], b[9], b[10], b[11]} == "WAVE") begin
      t = FT_WAV;
    end else if ({b[0], b[1], b[2]} == 24'h494433) begin
      t = FT_MP3;
    end else if ({b[0], b[1], b[2], b[3]} == "fLaC") begin
      t = FT_FLAC;
    end else if ({b[0], b[1], b[2], b[3]} == "OggS") begin
      t = FT_OGG;
    end else if ({b[0], b[1], b[2], b[3]} == 32'h25504446) begin
      t = FT_PDF;
    end else if ({b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} ==
                 64'hD0CF11E0_A1B11AE1) begin
      t = FT_DOC;
    end else if ({b[0], b[1], b[2], b[3]} == 32'h504B0304) begin
      t = FT_ZIP;
    end else if ({b[0], b[1], b[2], b[3], b[4], b[5], b[6]} == 56'h52617221_1A0700 ||
                 {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} ==
                 64'h52617221_1A070100) begin
      t = FT_RAR;
    end else if ({b[0], b[1], b[2], b[3], b[4], b[5]} == 48'h377ABCAF_271C) begin
      t = FT_7Z;
    end else begin
      t = FT_NONE;
    end
    return t;
  endfunction

endpackage

@@ sv/file_signature_classifier_unit.sv @@
// top level: registered magic number classifier for a 16-byte cluster start window
// an accepted beat is registered in in_q, classified, and its result and strobe come from res_q and res_vld_q
// throughput: one beat per cycle, busy_o stays low, set by the single match stage
// results cannot be stalled, each strobe lasts exactly one cycle
// reset clears the input and result valid flags only, no result follows reset
module file_signature_classifier_unit
  import fsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  fsc_in_t  req_i,
  output logic     valid_o,
  output fsc_res_t res_o
);

  logic     in_vld_q;
  fsc_in_t  in_q;
  logic     res_vld_q;
  fsc_res_t res_d;
  fsc_res_t res_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= req_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    res_d.file_type  = classify(in_q);
    res_d.recognized = (res_d.file_type != FT_NONE);
  end

  assign valid_o = res_vld_q;
  assign res_o   = res_q;

endmodule

@@ sv/fsc_checker.sv @@
// port level checker for the file signature classifier and its bind
module fsc_checker
  import fsc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     valid_o,
  input fsc_res_t res_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 valid_o)
    else $error("accepted beat gave no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##2 !valid_o)
    else $error("result without accepted beat");

  a_recognized_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.recognized == (res_o.file_type != FT_NONE)))
    else $error("recognized flag disagrees with file type");

  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.file_type <= FT_LAST))
    else $error("file type code out of range");

endmodule

bind file_signature_classifier_unit fsc_checker u_fsc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .res_o   (res_o)
);
